FILE: rtl/core/cnms_pkg.sv
// Shared constants and controller/datapath handshake types for the ring max-sum core.
package cnms_pkg;

    localparam int MAX_ITEMS = 16;

    localparam int VAL_W     = 8;
    localparam int SUM_OUT_W = 11;
    localparam int IDX_OUT_W = 4;

    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W     = $clog2((MAX_ITEMS / 2) * (2 ** VAL_W - 1) + 1);
    // ring position plus rotation, before the wrap
    localparam int JW        = CNT_W + 1;

    localparam int NUM_ROT   = 3;
    localparam int SC_DEPTH  = NUM_ROT * MAX_ITEMS;
    localparam int SC_AW     = $clog2(SC_DEPTH);

    localparam int TR_CAP    = MAX_ITEMS / 2 + 1;
    localparam int TR_IW     = $clog2(TR_CAP);
    localparam int TR_CW     = $clog2(TR_CAP + 1);

    localparam int SMALL_MAX = 3;

    localparam logic [1:0] LAST_ROT = 2'd2;
    localparam logic [1:0] OFF_NEAR = 2'd2;
    localparam logic [1:0] OFF_FAR  = 2'd3;

    typedef struct packed {
        logic load_en;
        logic start;
        logic scan_issue;
        logic dp_issue;
        logic best_upd;
        logic tr_init;
        logic tr_zero;
        logic tr_rd_a;
        logic tr_rd_b;
        logic tr_cmp;
        logic em_init;
        logic em_addr;
        logic em_load;
        logic sm_load;
        logic set_done;
    } t_dp_cmd;

    typedef struct packed {
        logic set_closed;
        logic small_set;
        logic scan_last;
        logic dp_last;
        logic rot_last;
        logic tr_more;
        logic k_two;
        logic em_last;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/core/cnms_if.sv
// Valid/ready channel interfaces for ring values in and picks out.
interface cnms_in_if;
    logic                       valid;
    logic                       ready;
    logic [cnms_pkg::VAL_W-1:0] value;
    logic                       last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface cnms_out_if;
    logic                           valid;
    logic                           ready;
    logic [cnms_pkg::SUM_OUT_W-1:0] best_sum;
    logic [cnms_pkg::IDX_OUT_W-1:0] pick_index;
    logic [cnms_pkg::VAL_W-1:0]     pick_value;
    logic                           last_pick;

    modport source (output valid, output best_sum, output pick_index, output pick_value,
                    output last_pick, input ready);
    modport sink   (input valid, input best_sum, input pick_index, input pick_value,
                    input last_pick, output ready);
endinterface

FILE: rtl/core/cnms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/cnms_ctrl.sv
// Sequencing state machine: load, scan or DP over three rotations, traceback, emit.
module cnms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cnms_pkg::t_dp_sts i_sts,
    output cnms_pkg::t_dp_cmd o_cmd
);
    import cnms_pkg::*;

    typedef enum logic [13:0] {
        S_LOAD   = 14'b00000000000001,
        S_START  = 14'b00000000000010,
        S_SCAN   = 14'b00000000000100,
        S_SDRAIN = 14'b00000000001000,
        S_SOUT   = 14'b00000000010000,
        S_DP     = 14'b00000000100000,
        S_DRAIN  = 14'b00000001000000,
        S_BEST   = 14'b00000010000000,
        S_TINIT  = 14'b00000100000000,
        S_TCHK   = 14'b00001000000000,
        S_TRD2   = 14'b00010000000000,
        S_TCMP   = 14'b00100000000000,
        S_ERD    = 14'b01000000000000,
        S_EWAIT  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load_en = 1'b1;
                if (i_sts.set_closed) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_sts.small_set ? S_SCAN : S_DP;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SDRAIN;
                end
            end
            S_SDRAIN: begin
                n_state = S_SOUT;
            end
            S_SOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.sm_load  = 1'b1;
                    o_cmd.set_done = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            S_DP: begin
                o_cmd.dp_issue = 1'b1;
                if (i_sts.dp_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_BEST;
            end
            S_BEST: begin
                o_cmd.best_upd = 1'b1;
                n_state        = i_sts.rot_last ? S_TINIT : S_DP;
            end
            S_TINIT: begin
                o_cmd.tr_init = 1'b1;
                n_state       = S_TCHK;
            end
            S_TCHK: begin
                if (!i_sts.tr_more) begin
                    o_cmd.em_init = 1'b1;
                    n_state       = S_ERD;
                end else if (i_sts.k_two) begin
                    o_cmd.tr_zero = 1'b1;
                end else begin
                    o_cmd.tr_rd_a = 1'b1;
                    n_state       = S_TRD2;
                end
            end
            S_TRD2: begin
                o_cmd.tr_rd_b = 1'b1;
                n_state       = S_TCMP;
            end
            S_TCMP: begin
                o_cmd.tr_cmp = 1'b1;
                n_state      = S_TCHK;
            end
            S_ERD: begin
                o_cmd.em_addr = 1'b1;
                n_state       = S_EWAIT;
            end
            S_EWAIT: begin
                o_cmd.em_addr = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.em_load = 1'b1;
                    if (i_sts.em_last) begin
                        o_cmd.set_done = 1'b1;
                        n_state        = S_LOAD;
                    end else begin
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end
endmodule

FILE: rtl/core/cnms_dp.sv
// Datapath: ring store, score store, DP window, best search, trace list, output register.
module cnms_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cnms_pkg::t_dp_cmd i_cmd,
    output cnms_pkg::t_dp_sts o_sts,
    cnms_in_if.sink           i_in_ch,
    cnms_out_if.source        o_out_ch
);
    import cnms_pkg::*;

    // control
    logic [CNT_W-1:0]     r_count;
    logic                 r_dv_dp;
    logic                 r_dv_sc;
    logic                 r_ov;

    // loop indices and DP window
    logic [IDX_W-1:0]     r_j;
    logic [IDX_W-1:0]     r_jd;
    logic [1:0]           r_rot;
    logic [SUM_W-1:0]     r_m1;
    logic [SUM_W-1:0]     r_m2;
    logic [SUM_W-1:0]     r_m3;

    // best search
    logic                 r_found;
    logic [SUM_W-1:0]     r_best;
    logic [1:0]           r_brot;
    logic [1:0]           r_boff;
    logic [VAL_W-1:0]     r_bv;
    logic [IDX_W-1:0]     r_bi;

    // traceback and emit
    logic [IDX_W-1:0]     r_k;
    logic [TR_CW-1:0]     r_cnt;
    logic [IDX_W-1:0]     r_trace [TR_CAP];
    logic [SUM_W-1:0]     r_ta;
    logic [TR_IW-1:0]     r_ei;

    // output register
    logic [SUM_OUT_W-1:0] r_o_sum;
    logic [IDX_OUT_W-1:0] r_o_idx;
    logic [VAL_W-1:0]     r_o_val;
    logic                 r_o_last;

    logic                 w_in_acc;
    logic                 w_store;
    logic [JW-1:0]        w_n_ext;
    logic [JW-1:0]        w_jr_sum;
    logic [JW-1:0]        w_jmod;
    logic [JW-1:0]        w_tr_sum;
    logic [JW-1:0]        w_pos;
    logic [IDX_W-1:0]     w_ring_raddr;
    logic [VAL_W-1:0]     w_ring_rdata;
    logic [SC_AW-1:0]     w_rot_base;
    logic [SC_AW-1:0]     w_brot_base;
    logic [SC_AW-1:0]     w_sc_waddr;
    logic [SC_AW-1:0]     w_sc_raddr;
    logic [IDX_W-1:0]     w_k_back;
    logic [SUM_W-1:0]     w_sc_rdata;
    logic [SUM_W-1:0]     w_prev_max;
    logic [SUM_W-1:0]     w_row;
    logic [SUM_W-1:0]     w_b1;
    logic [1:0]           w_o1;
    logic [1:0]           w_r1;
    logic [SUM_W-1:0]     w_b2;
    logic [1:0]           w_o2;
    logic [1:0]           w_r2;
    logic [IDX_W-1:0]     w_k_init;
    logic [IDX_W-1:0]     w_k_next;
    logic                 w_em_last;

    assign w_in_acc       = i_in_ch.valid && i_cmd.load_en;
    assign w_store        = w_in_acc && (r_count < CNT_W'(MAX_ITEMS));
    assign i_in_ch.ready  = i_cmd.load_en;

    // ring position wrap: operands stay below twice the ring length
    assign w_n_ext  = {1'b0, r_count};
    assign w_jr_sum = JW'(r_j) + JW'(r_rot);
    assign w_jmod   = (w_jr_sum >= w_n_ext) ? (w_jr_sum - w_n_ext) : w_jr_sum;
    assign w_tr_sum = JW'(r_trace[r_ei]) + JW'(r_brot);
    assign w_pos    = (w_tr_sum >= w_n_ext) ? (w_tr_sum - w_n_ext) : w_tr_sum;

    assign w_ring_raddr = i_cmd.em_addr ? w_pos[IDX_W-1:0] : w_jmod[IDX_W-1:0];

    cnms_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ITEMS)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_in_ch.value),
        .i_raddr (w_ring_raddr),
        .o_rdata (w_ring_rdata)
    );

    assign w_rot_base  = SC_AW'(r_rot * MAX_ITEMS);
    assign w_brot_base = SC_AW'(r_brot * MAX_ITEMS);
    assign w_sc_waddr  = w_rot_base + SC_AW'(r_jd);
    assign w_k_back    = i_cmd.tr_rd_a ? (r_k - IDX_W'(OFF_NEAR)) : (r_k - IDX_W'(OFF_FAR));
    assign w_sc_raddr  = w_brot_base + SC_AW'(w_k_back);

    cnms_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SC_DEPTH)
    ) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (r_dv_dp),
        .i_waddr (w_sc_waddr),
        .i_wdata (w_row),
        .i_raddr (w_sc_raddr),
        .o_rdata (w_sc_rdata)
    );

    // score at rotated position 1 is always zero
    assign w_prev_max = (r_m2 > r_m3) ? r_m2 : r_m3;
    assign w_row      = (r_jd == IDX_W'(1)) ? '0 : (w_prev_max + SUM_W'(w_ring_rdata));

    // end at n-2 is tried before n-3; first maximum holds on a tie
    always_comb begin
        w_b1 = r_best;
        w_o1 = r_boff;
        w_r1 = r_brot;
        if (!r_found || (r_m1 > r_best)) begin
            w_b1 = r_m1;
            w_o1 = OFF_NEAR;
            w_r1 = r_rot;
        end
        w_b2 = w_b1;
        w_o2 = w_o1;
        w_r2 = w_r1;
        if (r_m2 > w_b1) begin
            w_b2 = r_m2;
            w_o2 = OFF_FAR;
            w_r2 = r_rot;
        end
    end

    assign w_k_init  = IDX_W'(r_count - CNT_W'(r_boff));
    assign w_k_next  = i_cmd.tr_zero ? '0 :
                       (r_ta > w_sc_rdata) ? (r_k - IDX_W'(OFF_NEAR)) : (r_k - IDX_W'(OFF_FAR));
    assign w_em_last = (r_ei == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dv_dp <= 1'b0;
            r_dv_sc <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.set_done) begin
                r_count <= '0;
            end else if (w_store) begin
                r_count <= r_count + 1'b1;
            end
            r_dv_dp <= i_cmd.dp_issue;
            r_dv_sc <= i_cmd.scan_issue;
            if (i_cmd.em_load || i_cmd.sm_load) begin
                r_ov <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_jd <= r_j;

        // advance the DP window behind the ring read
        if (r_dv_dp) begin
            r_m3 <= r_m2;
            r_m2 <= r_m1;
            r_m1 <= w_row;
        end

        if (i_cmd.start) begin
            r_j     <= '0;
            r_rot   <= '0;
            r_found <= 1'b0;
            r_m1    <= '0;
            r_m2    <= '0;
            r_m3    <= '0;
        end else if (i_cmd.best_upd) begin
            r_j     <= '0;
            r_rot   <= r_rot + 1'b1;
            r_found <= 1'b1;
            r_best  <= w_b2;
            r_boff  <= w_o2;
            r_brot  <= w_r2;
            r_m1    <= '0;
            r_m2    <= '0;
            r_m3    <= '0;
        end else if (i_cmd.scan_issue || i_cmd.dp_issue) begin
            r_j <= r_j + 1'b1;
        end

        if (r_dv_sc) begin
            if ((r_jd == '0) || (w_ring_rdata > r_bv)) begin
                r_bv <= w_ring_rdata;
                r_bi <= r_jd;
            end
        end

        if (i_cmd.tr_init) begin
            r_k        <= w_k_init;
            r_trace[0] <= w_k_init;
            r_cnt      <= TR_CW'(1);
        end else if (i_cmd.tr_zero || i_cmd.tr_cmp) begin
            r_k                         <= w_k_next;
            r_trace[r_cnt[TR_IW-1:0]]   <= w_k_next;
            r_cnt                       <= r_cnt + 1'b1;
        end

        if (i_cmd.tr_rd_b) begin
            r_ta <= w_sc_rdata;
        end

        // picks come out in reverse trace order
        if (i_cmd.em_init) begin
            r_ei <= TR_IW'(r_cnt - 1'b1);
        end else if (i_cmd.em_load) begin
            r_ei <= r_ei - 1'b1;
        end

        if (i_cmd.em_load) begin
            r_o_sum  <= SUM_OUT_W'(r_best);
            r_o_idx  <= IDX_OUT_W'(w_pos);
            r_o_val  <= w_ring_rdata;
            r_o_last <= w_em_last;
        end else if (i_cmd.sm_load) begin
            r_o_sum  <= SUM_OUT_W'(r_bv);
            r_o_idx  <= IDX_OUT_W'(r_bi);
            r_o_val  <= r_bv;
            r_o_last <= 1'b1;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.set_closed = w_in_acc && i_in_ch.last_item;
        o_sts.small_set  = (r_count <= CNT_W'(SMALL_MAX));
        o_sts.scan_last  = ((JW'(r_j) + JW'(1)) == w_n_ext);
        o_sts.dp_last    = ((JW'(r_j) + JW'(OFF_NEAR)) == w_n_ext);
        o_sts.rot_last   = (r_rot == LAST_ROT);
        o_sts.tr_more    = (r_k > IDX_W'(1)) && (r_cnt < TR_CW'(TR_CAP));
        o_sts.k_two      = (r_k == IDX_W'(OFF_NEAR));
        o_sts.em_last    = w_em_last;
        o_sts.out_free   = !r_ov || o_out_ch.ready;
    end

    assign o_out_ch.valid      = r_ov;
    assign o_out_ch.best_sum   = r_o_sum;
    assign o_out_ch.pick_index = r_o_idx;
    assign o_out_ch.pick_value = r_o_val;
    assign o_out_ch.last_pick  = r_o_last;
endmodule

FILE: rtl/core/circular_nonadjacent_max_sum_core.sv
// Values load at one item per cycle while the core is in its load state; after the closing
// item a set of n <= 3 values is scanned and raises its largest value as the pick, a larger
// set runs the DP over three rotations, then traces its picks back and emits them in turn.
// Sets are worked on one at a time.
// Reset: synchronous, active low; clears the state machine, item count and output valid,
// RAM contents are left as they are.
module circular_nonadjacent_max_sum_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cnms_in_if.sink     i_in_ch,
    cnms_out_if.source  o_out_ch
);
    import cnms_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    cnms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    cnms_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_in_ch  (i_in_ch),
        .o_out_ch (o_out_ch)
    );
endmodule

FILE: rtl/core/cnms_chk.sv
// Port-level checker for the ring max-sum core, with its bind.
module cnms_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_last_item,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [cnms_pkg::SUM_OUT_W-1:0] i_out_best_sum,
    input logic [cnms_pkg::IDX_OUT_W-1:0] i_out_pick_index,
    input logic [cnms_pkg::VAL_W-1:0]     i_out_pick_value,
    input logic                           i_out_last_pick
);
    import cnms_pkg::*;

    // a stalled pick holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_best_sum) &&
            $stable(i_out_pick_index) && $stable(i_out_pick_value) &&
            $stable(i_out_last_pick)))
        else $error("pick changed while stalled");

    // closing item stops loading while the set is worked on
    a_close_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last_item) |=> !i_in_ready)
        else $error("input taken right after closing item");

    // no new values until the final pick of a set is in the output register
    a_no_load_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last_pick) |-> !i_in_ready)
        else $error("input ready during pick emission");

    // every pick is part of the best sum
    a_sum_covers_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_best_sum >= SUM_OUT_W'(i_out_pick_value)))
        else $error("best sum below picked value");
endmodule

bind circular_nonadjacent_max_sum_core cnms_chk u_cnms_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_ch.valid),
    .i_in_ready       (i_in_ch.ready),
    .i_in_last_item   (i_in_ch.last_item),
    .i_out_valid      (o_out_ch.valid),
    .i_out_ready      (o_out_ch.ready),
    .i_out_best_sum   (o_out_ch.best_sum),
    .i_out_pick_index (o_out_ch.pick_index),
    .i_out_pick_value (o_out_ch.pick_value),
    .i_out_last_pick  (o_out_ch.last_pick)
);
